[src/afc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB frustum containment package
// Shared constants, register indexes and pipeline control types for the
// box-against-frustum containment test.
// ----------------------------------------------------------------------------
package afc_pkg;

   // Default fixed-point widths of box coordinates and plane normals.
   localparam int DEF_COORD_WIDTH  = 24;
   localparam int DEF_NORMAL_WIDTH = 12;

   // Each plane register packs three normals and an offset into 64 bits.
   localparam int PLANE_WIDTH      = 64;
   localparam int NUM_PLANES       = 6;
   localparam int NUM_AXES         = 3;
   localparam int CSR_INDEX_WIDTH  = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      PLANE_NEAR   = 3'd0,
      PLANE_FAR    = 3'd1,
      PLANE_LEFT   = 3'd2,
      PLANE_RIGHT  = 3'd3,
      PLANE_BOTTOM = 3'd4,
      PLANE_TOP    = 3'd5
   } plane_idx_type;

   // Load enables of the per-plane pipeline stages.
   typedef struct packed {
      logic mul_en;   // product stage loads
      logic sum_en;   // partial-sum stage loads
   } stage_en_type;

endpackage : afc_pkg
`default_nettype wire

[src/afc_plane_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB frustum plane test
// Tests one box against one clipping plane. For each axis the corner
// coordinate that maximizes the normal product is chosen, the three products
// are registered, then folded into two partial sums that are compared.
// ----------------------------------------------------------------------------
module afc_plane_test #(
   parameter int COORD_WIDTH  = afc_pkg::DEF_COORD_WIDTH,
   parameter int NORMAL_WIDTH = afc_pkg::DEF_NORMAL_WIDTH
) (
   input  wire                               clock,
   input  wire  afc_pkg::stage_en_type       en,
   input  wire  [afc_pkg::PLANE_WIDTH-1:0]   plane,
   input  wire  signed [COORD_WIDTH-1:0]     box_max [afc_pkg::NUM_AXES],
   input  wire  signed [COORD_WIDTH-1:0]     box_min [afc_pkg::NUM_AXES],
   output logic                              outside
);
   import afc_pkg::*;

   localparam int OFFSET_WIDTH = PLANE_WIDTH - NUM_AXES * NORMAL_WIDTH;
   localparam int PROD_WIDTH   = COORD_WIDTH + NORMAL_WIDTH;
   localparam int SCALED_WIDTH = OFFSET_WIDTH + NORMAL_WIDTH - 2;
   localparam int WIDE_WIDTH   = (SCALED_WIDTH > PROD_WIDTH) ? SCALED_WIDTH : PROD_WIDTH;
   localparam int ACC_WIDTH    = WIDE_WIDTH + 2;

   logic signed [NORMAL_WIDTH-1:0] normal [NUM_AXES];
   logic signed [OFFSET_WIDTH-1:0] offset;
   logic signed [COORD_WIDTH-1:0]  coord  [NUM_AXES];
   logic signed [PROD_WIDTH-1:0]   prod_in [NUM_AXES];
   logic signed [PROD_WIDTH-1:0]   prod_ff [NUM_AXES];
   logic signed [ACC_WIDTH-1:0]    lhs_in, lhs_ff;
   logic signed [ACC_WIDTH-1:0]    rhs_in, rhs_ff;

   // Unpack the plane register.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         normal[k] = $signed(plane[k*NORMAL_WIDTH +: NORMAL_WIDTH]);
      end
      offset = $signed(plane[PLANE_WIDTH-1 -: OFFSET_WIDTH]);
   end

   // A nonnegative normal is largest at the larger coordinate, a negative one
   // at the smaller; the sum of per-axis maxima is the worst corner.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         coord[k]   = normal[k][NORMAL_WIDTH-1] ? box_min[k] : box_max[k];
         prod_in[k] = PROD_WIDTH'(coord[k]) * PROD_WIDTH'(normal[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Split the four-term sum across the partial-sum stage and the compare.
   always_comb begin
      lhs_in = ACC_WIDTH'(prod_ff[0]) + ACC_WIDTH'(prod_ff[1]);
      rhs_in = (ACC_WIDTH'(offset) <<< (NORMAL_WIDTH - 2)) - ACC_WIDTH'(prod_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en.sum_en) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
   end

   // The worst corner lies strictly in front of the plane.
   assign outside = lhs_ff > rhs_ff;

endmodule : afc_plane_test
`default_nettype wire

[src/aabb_frustum_containment_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB frustum containment test
// Reports whether an axis-aligned box lies wholly on or behind six planes.
// ----------------------------------------------------------------------------
// The block accepts one box per clock cycle while the result side is not
// stalled and returns one result per box, in order. The pipeline has four
// register stages: per-axis min/max ordering of the box corners, eighteen
// coordinate-by-normal multipliers (three per plane, each selecting its worst
// corner by the sign of the normal), two partial sums per plane, and the six
// plane compares joined into the output register. Each stage holds its item
// under back-pressure and empty stages fill independently, so a stall loses
// and repeats nothing. Plane registers reset to zero, which makes every box
// report as inside; they may be written only while no box is in flight.
// ----------------------------------------------------------------------------
module aabb_frustum_containment_test #(
   parameter int COORD_WIDTH  = afc_pkg::DEF_COORD_WIDTH,
   parameter int NORMAL_WIDTH = afc_pkg::DEF_NORMAL_WIDTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Box input stream.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // From bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z.
   input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // Result stream.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // Bit 0: inside_res; upper bits are zero.
   output logic [7:0]                            rsp_tdata,
   // Plane register writes.
   input  wire                                   csr_we,
   input  wire  [afc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [afc_pkg::PLANE_WIDTH-1:0]       csr_wdata
);
   import afc_pkg::*;

   logic [PLANE_WIDTH-1:0]         planes_ff [NUM_PLANES];

   logic signed [COORD_WIDTH-1:0]  box_lo    [NUM_AXES];
   logic signed [COORD_WIDTH-1:0]  box_hi    [NUM_AXES];
   logic signed [COORD_WIDTH-1:0]  max_in    [NUM_AXES];
   logic signed [COORD_WIDTH-1:0]  min_in    [NUM_AXES];
   logic signed [COORD_WIDTH-1:0]  max_ff    [NUM_AXES];
   logic signed [COORD_WIDTH-1:0]  min_ff    [NUM_AXES];

   logic                           ord_valid_ff, mul_valid_ff, sum_valid_ff, rsp_valid_ff;
   logic                           ord_adv, mul_adv, sum_adv, rsp_adv;
   logic                           rsp_inside_in, rsp_inside_ff;
   logic [NUM_PLANES-1:0]          outside;
   stage_en_type                   stage_en;

   // Plane registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            planes_ff[p] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            PLANE_NEAR:   planes_ff[PLANE_NEAR]   <= csr_wdata;
            PLANE_FAR:    planes_ff[PLANE_FAR]    <= csr_wdata;
            PLANE_LEFT:   planes_ff[PLANE_LEFT]   <= csr_wdata;
            PLANE_RIGHT:  planes_ff[PLANE_RIGHT]  <= csr_wdata;
            PLANE_BOTTOM: planes_ff[PLANE_BOTTOM] <= csr_wdata;
            PLANE_TOP:    planes_ff[PLANE_TOP]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Each stage loads when it is empty or its item moves on.
   assign rsp_adv    = !rsp_valid_ff || rsp_tready;
   assign sum_adv    = !sum_valid_ff || rsp_adv;
   assign mul_adv    = !mul_valid_ff || sum_adv;
   assign ord_adv    = !ord_valid_ff || mul_adv;
   assign req_tready = ord_adv;

   assign stage_en.mul_en = mul_adv && ord_valid_ff;
   assign stage_en.sum_en = sum_adv && mul_valid_ff;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         ord_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ord_adv) begin
            ord_valid_ff <= req_tvalid;
         end
         if (mul_adv) begin
            mul_valid_ff <= ord_valid_ff;
         end
         if (sum_adv) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (rsp_adv) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   // Order the two corner coordinates on each axis.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         box_lo[k] = $signed(req_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
         box_hi[k] = $signed(req_tdata[(k+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH]);
         max_in[k] = (box_hi[k] >= box_lo[k]) ? box_hi[k] : box_lo[k];
         min_in[k] = (box_hi[k] >= box_lo[k]) ? box_lo[k] : box_hi[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_adv && req_tvalid) begin
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   // One plane test per clipping plane.
   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      afc_plane_test #(
         .COORD_WIDTH  (COORD_WIDTH),
         .NORMAL_WIDTH (NORMAL_WIDTH)
      ) u_plane (
         .clock   (clock),
         .en      (stage_en),
         .plane   (planes_ff[p]),
         .box_max (max_ff),
         .box_min (min_ff),
         .outside (outside[p])
      );
   end

   // Output register: inside only when no plane rejects the box.
   assign rsp_inside_in = ~|outside;

   always_ff @(posedge clock) begin
      if (rsp_adv && sum_valid_ff) begin
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_inside_ff};

   // Reset empties every stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !ord_valid_ff && !mul_valid_ff && !sum_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // An input transfer always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ord_valid_ff)
      else $error("accepted box did not enter the pipeline");

   // A blocked partial-sum stage keeps its item.
   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !rsp_adv |=> sum_valid_ff)
      else $error("partial-sum stage dropped a stalled item");

   // Corner ordering puts the larger coordinate in the max register.
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      ord_valid_ff |-> (max_ff[0] >= min_ff[0]) && (max_ff[1] >= min_ff[1])
                       && (max_ff[2] >= min_ff[2]))
      else $error("corner ordering out of order");

endmodule : aabb_frustum_containment_test
`default_nettype wire
